@@ rtl/core/jps_pkg.sv @@
// Shared types, codes, constants and helper functions of the jump phase sequencer.
package jps_pkg;

  // Jump phases, also the encoding of the phase_now result field
  typedef enum logic [2:0] {
    PH_PREPARE = 3'd0,
    PH_PUSH    = 3'd1,
    PH_FLY     = 3'd2,
    PH_LAND    = 3'd3,
    PH_RECOVER = 3'd4
  } jps_phase_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_RAMP   = 3'd1,
    S_RECIP  = 3'd2,
    S_YAW    = 3'd3,
    S_COMMIT = 3'd4
  } jps_state_e;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_RAMP  = 2'd0,
    MUL_RECIP = 2'd1,
    MUL_YAW   = 2'd2
  } jps_mul_sel_e;

  // Jump kinds (codes above JK_TURN_RIGHT behave as no jump)
  localparam logic [2:0] JK_FORWARD    = 3'd1;
  localparam logic [2:0] JK_BACKWARD   = 3'd2;
  localparam logic [2:0] JK_TURN_LEFT  = 3'd3;
  localparam logic [2:0] JK_TURN_RIGHT = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_JUMP_KIND  = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
  localparam logic [2:0] REG_LEFT_LOW   = 3'd2;
  localparam logic [2:0] REG_LEFT_HIGH  = 3'd3;
  localparam logic [2:0] REG_RIGHT_LOW  = 3'd4;
  localparam logic [2:0] REG_RIGHT_HIGH = 3'd5;

  // Operation codes
  localparam logic OP_START = 1'b0;

  // Angles in Q3.12
  localparam logic signed [17:0] Q_PI        = 18'sd12868;
  localparam logic signed [17:0] Q_TWO_PI    = 18'sd25736;
  localparam logic signed [17:0] Q_THREE_PI  = 18'sd38604;
  localparam logic signed [17:0] Q_FOUR_PI   = 18'sd51472;
  localparam logic signed [17:0] Q_HALF_PI   = 18'sd6434;

  // Pitch stability window
  localparam logic signed [15:0] PITCH_LIMIT = 16'sd737;
  localparam logic signed [15:0] RATE_LIMIT  = 16'sd6553;

  // Push ramp: velocity = min(speed, cap) * min(timer, ramp) / ramp.
  // The division is a right shift followed by a reciprocal multiply.
  localparam logic [7:0]  RAMP_FWD       = 8'd160;
  localparam logic [7:0]  RAMP_BWD       = 8'd240;
  localparam logic [14:0] CAP_FWD        = 15'd1638;
  localparam logic [14:0] CAP_BWD        = 15'd1393;
  localparam int          PRE_SHIFT_FWD  = 5;   // 160 = 32 * 5
  localparam int          PRE_SHIFT_BWD  = 4;   // 240 = 16 * 15
  localparam logic signed [16:0] RECIP_FWD = 17'sd13108;  // ceil(2^16 / 5)
  localparam logic signed [16:0] RECIP_BWD = 17'sd17477;  // ceil(2^18 / 15)
  localparam int          RECIP_SHIFT_FWD = 16;
  localparam int          RECIP_SHIFT_BWD = 18;

  // Phase durations in milliseconds
  localparam int PUSH_WAIT_FWD    = 650;
  localparam int PUSH_WAIT_BWD    = 700;
  localparam int PUSH_WAIT_NONE   = 200;
  localparam int FLY_WAIT         = 130;
  localparam int LAND_WAIT        = 260;
  localparam int STABLE_WAIT      = 80;
  localparam int RECOVER_TIMEOUT  = 350;

  // Yaw loop gains (Q3.12), feed-forward rates and rate limits
  localparam logic signed [16:0] KP_STRAIGHT = 17'sd12288;
  localparam logic signed [16:0] KP_TURN     = 17'sd4096;
  localparam logic signed [16:0] KP_PUSH     = 17'sd5734;
  localparam logic signed [16:0] KP_FLY      = 17'sd8192;
  localparam logic signed [16:0] KP_LAND     = 17'sd1434;
  localparam logic signed [16:0] KP_RECOVER  = 17'sd3277;
  localparam logic signed [19:0] FF_PUSH     = 20'sd4915;
  localparam logic signed [19:0] FF_FLY      = 20'sd26214;
  localparam logic signed [19:0] MR_STRAIGHT = 20'sd7373;
  localparam logic signed [19:0] MR_TURN     = 20'sd2458;
  localparam logic signed [19:0] MR_PUSH     = 20'sd7373;
  localparam logic signed [19:0] MR_FLY      = 20'sd26214;
  localparam logic signed [19:0] MR_LAND     = 20'sd1638;
  localparam logic signed [19:0] MR_RECOVER  = 20'sd2048;
  localparam logic signed [33:0] ROUND_HALF  = 34'sd2048;

  // Pose arguments
  localparam logic signed [7:0] SERVO_LOW_OFS  = 8'sd60;
  localparam logic signed [7:0] SERVO_HIGH_OFS = 8'sd20;
  localparam logic [8:0]        AUX_A_PREPARE  = 9'd450;
  localparam logic [7:0]        AUX_B_PREPARE  = 8'd250;

  // Controller to datapath commands
  typedef struct packed {
    logic         load;
    logic         mul_en;
    jps_mul_sel_e mul_sel;
    logic         commit;
  } jps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_free;
  } jps_status_t;

  // One result word
  typedef struct packed {
    logic               pose_valid;
    logic [11:0]        pose_left;
    logic [11:0]        pose_right;
    logic [8:0]         pose_aux_a;
    logic [7:0]         pose_aux_b;
    logic signed [15:0] linear_velocity;
    logic signed [15:0] yaw_rate_cmd;
    logic               yaw_control_on;
    logic               linear_feedback_on;
    logic               clear_yaw_integral;
    logic               finished;
    logic [2:0]         phase_now;
  } jps_res_t;

  // Wrap an angle into (-PI, PI]; the input never exceeds two turns either way
  function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
    logic signed [17:0] r;
    if (a > Q_THREE_PI) begin
      r = a - Q_FOUR_PI;
    end else if (a > Q_PI) begin
      r = a - Q_TWO_PI;
    end else if (a <= -Q_THREE_PI) begin
      r = a + Q_FOUR_PI;
    end else if (a <= -Q_PI) begin
      r = a + Q_TWO_PI;
    end else begin
      r = a;
    end
    return r[15:0];
  endfunction

  // Servo base plus offset, saturated to 0..4095
  function automatic logic [11:0] servo_sum(input logic [11:0] base,
                                            input logic signed [7:0] delta);
    logic signed [13:0] s;
    s = $signed({2'b00, base}) + $signed({{6{delta[7]}}, delta});
    if (s < 14'sd0) begin
      return 12'd0;
    end else if (s > 14'sd4095) begin
      return 12'd4095;
    end else begin
      return s[11:0];
    end
  endfunction

endpackage

@@ rtl/core/jps_if.sv @@
// Channel interfaces of the jump phase sequencer: input, result and configuration.
interface jps_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         tick_length;
  logic signed [15:0] yaw_now;
  logic signed [15:0] pitch_now;
  logic signed [15:0] pitch_speed;

  modport source (output valid, operation, tick_length, yaw_now, pitch_now, pitch_speed,
                  input ready);
  modport sink   (input valid, operation, tick_length, yaw_now, pitch_now, pitch_speed,
                  output ready);
endinterface

interface jps_res_if;
  logic               valid;
  logic               ready;
  logic               pose_valid;
  logic [11:0]        pose_left;
  logic [11:0]        pose_right;
  logic [8:0]         pose_aux_a;
  logic [7:0]         pose_aux_b;
  logic signed [15:0] linear_velocity;
  logic signed [15:0] yaw_rate_cmd;
  logic               yaw_control_on;
  logic               linear_feedback_on;
  logic               clear_yaw_integral;
  logic               finished;
  logic [2:0]         phase_now;

  modport source (output valid, pose_valid, pose_left, pose_right, pose_aux_a, pose_aux_b,
                  linear_velocity, yaw_rate_cmd, yaw_control_on, linear_feedback_on,
                  clear_yaw_integral, finished, phase_now,
                  input ready);
  modport sink   (input valid, pose_valid, pose_left, pose_right, pose_aux_a, pose_aux_b,
                  linear_velocity, yaw_rate_cmd, yaw_control_on, linear_feedback_on,
                  clear_yaw_integral, finished, phase_now,
                  output ready);
endinterface

interface jps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/jps_ctrl.sv @@
// Controller of the jump phase sequencer: sequences load, three multiplies and commit.
module jps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jps_pkg::jps_status_t status_i,
  output jps_pkg::jps_cmd_t    cmd_o
);

  jps_pkg::jps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = jps_pkg::MUL_RAMP;
    unique case (state_q)
      jps_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = jps_pkg::S_RAMP;
        end
      end
      jps_pkg::S_RAMP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = jps_pkg::MUL_RAMP;
        state_d       = jps_pkg::S_RECIP;
      end
      jps_pkg::S_RECIP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = jps_pkg::MUL_RECIP;
        state_d       = jps_pkg::S_YAW;
      end
      jps_pkg::S_YAW: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = jps_pkg::MUL_YAW;
        state_d       = jps_pkg::S_COMMIT;
      end
      jps_pkg::S_COMMIT: begin
        // hold until the result register can take the word
        if (status_i.res_free) begin
          cmd_o.commit = 1'b1;
          state_d      = jps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = jps_pkg::S_IDLE;
      end
    endcase
  end

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> status_i.res_free)
    else $error("commit while the result register is occupied");

  a_load_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> ##4 (state_q == jps_pkg::S_COMMIT))
    else $error("item did not reach commit four cycles after load");

endmodule

@@ rtl/core/jps_dp.sv @@
// Datapath of the jump phase sequencer: registers, phase state, shared multiplier, result.
module jps_dp #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jps_pkg::jps_cmd_t    cmd_i,
  output jps_pkg::jps_status_t status_o,
  input  logic                 operation_i,
  input  logic [7:0]           tick_length_i,
  input  logic signed [15:0]   yaw_now_i,
  input  logic signed [15:0]   pitch_now_i,
  input  logic signed [15:0]   pitch_speed_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [14:0]          cfg_data_i,
  output jps_pkg::jps_res_t    res_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i
);

  localparam logic [TIMER_WIDTH-1:0] WAIT_FWD  = TIMER_WIDTH'(jps_pkg::PUSH_WAIT_FWD);
  localparam logic [TIMER_WIDTH-1:0] WAIT_BWD  = TIMER_WIDTH'(jps_pkg::PUSH_WAIT_BWD);
  localparam logic [TIMER_WIDTH-1:0] WAIT_NONE = TIMER_WIDTH'(jps_pkg::PUSH_WAIT_NONE);
  localparam logic [TIMER_WIDTH-1:0] WAIT_FLY  = TIMER_WIDTH'(jps_pkg::FLY_WAIT);
  localparam logic [TIMER_WIDTH-1:0] WAIT_LAND = TIMER_WIDTH'(jps_pkg::LAND_WAIT);
  localparam logic [TIMER_WIDTH-1:0] WAIT_STBL = TIMER_WIDTH'(jps_pkg::STABLE_WAIT);
  localparam logic [TIMER_WIDTH-1:0] WAIT_TOUT = TIMER_WIDTH'(jps_pkg::RECOVER_TIMEOUT);

  // configuration
  logic [2:0]  jump_kind_q;
  logic [14:0] max_speed_q;
  logic [11:0] left_low_q, left_high_q, right_low_q, right_high_q;

  // captured item
  logic               op_q;
  logic [7:0]         tick_q;
  logic signed [15:0] yaw_q;
  logic               stable_q;

  // jump state
  jps_pkg::jps_phase_e     phase_q, phase_d;
  logic [TIMER_WIDTH-1:0]  ptimer_q, ptimer_d;
  logic [TIMER_WIDTH-1:0]  relapsed_q, relapsed_d;
  logic signed [15:0]      ytarget_q, ytarget_d;

  // arithmetic
  logic signed [15:0] err_q;
  logic signed [33:0] prod_q, prod_d;
  logic signed [15:0] vel_q, vel_d;
  logic signed [16:0] mul_a, mul_b;

  // result
  jps_pkg::jps_res_t res_q, res_d;
  logic              res_valid_q;

  logic lin_fwd, lin_bwd, spin_ccw, spin_cw, lin_jump, turn_jump, steer_jump;

  assign lin_fwd    = (jump_kind_q == jps_pkg::JK_FORWARD);
  assign lin_bwd    = (jump_kind_q == jps_pkg::JK_BACKWARD);
  assign spin_ccw   = (jump_kind_q == jps_pkg::JK_TURN_LEFT);
  assign spin_cw    = (jump_kind_q == jps_pkg::JK_TURN_RIGHT);
  assign lin_jump   = lin_fwd | lin_bwd;
  assign turn_jump  = spin_ccw | spin_cw;
  assign steer_jump = lin_jump | turn_jump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_kind_q  <= 3'd0;
      max_speed_q  <= 15'd1638;
      left_low_q   <= 12'd0;
      left_high_q  <= 12'd4095;
      right_low_q  <= 12'd0;
      right_high_q <= 12'd4095;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jps_pkg::REG_JUMP_KIND:  jump_kind_q  <= cfg_data_i[2:0];
        jps_pkg::REG_MAX_SPEED:  max_speed_q  <= cfg_data_i;
        jps_pkg::REG_LEFT_LOW:   left_low_q   <= cfg_data_i[11:0];
        jps_pkg::REG_LEFT_HIGH:  left_high_q  <= cfg_data_i[11:0];
        jps_pkg::REG_RIGHT_LOW:  right_low_q  <= cfg_data_i[11:0];
        jps_pkg::REG_RIGHT_HIGH: right_high_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      tick_q   <= tick_length_i;
      yaw_q    <= yaw_now_i;
      stable_q <= (pitch_now_i >= -jps_pkg::PITCH_LIMIT) &&
                  (pitch_now_i <= jps_pkg::PITCH_LIMIT) &&
                  (pitch_speed_i >= -jps_pkg::RATE_LIMIT) &&
                  (pitch_speed_i <= jps_pkg::RATE_LIMIT);
    end
  end

  // ---------------------------------------------------------------- multiplier
  logic [7:0]         ramp_len, ramp_t;
  logic [14:0]        ramp_cap, ramp_pv;
  logic [33:0]        pre_shifted, post_shifted;
  logic [10:0]        vel_mag;
  logic signed [16:0] kp_sel;
  logic signed [17:0] ydiff;

  always_comb begin
    ramp_len = lin_fwd ? jps_pkg::RAMP_FWD : jps_pkg::RAMP_BWD;
    ramp_cap = lin_fwd ? jps_pkg::CAP_FWD : jps_pkg::CAP_BWD;
    ramp_t   = (ptimer_q < TIMER_WIDTH'(ramp_len)) ? ptimer_q[7:0] : ramp_len;
    ramp_pv  = (max_speed_q < ramp_cap) ? max_speed_q : ramp_cap;

    pre_shifted  = lin_fwd ? (prod_q >> jps_pkg::PRE_SHIFT_FWD)
                           : (prod_q >> jps_pkg::PRE_SHIFT_BWD);
    post_shifted = lin_fwd ? (prod_q >> jps_pkg::RECIP_SHIFT_FWD)
                           : (prod_q >> jps_pkg::RECIP_SHIFT_BWD);
    vel_mag      = post_shifted[10:0];

    kp_sel = jps_pkg::KP_STRAIGHT;
    if (turn_jump) begin
      case (phase_q)
        jps_pkg::PH_PUSH:    kp_sel = jps_pkg::KP_PUSH;
        jps_pkg::PH_FLY:     kp_sel = jps_pkg::KP_FLY;
        jps_pkg::PH_LAND:    kp_sel = jps_pkg::KP_LAND;
        jps_pkg::PH_RECOVER: kp_sel = jps_pkg::KP_RECOVER;
        default:             kp_sel = jps_pkg::KP_TURN;
      endcase
    end

    case (cmd_i.mul_sel)
      jps_pkg::MUL_RAMP: begin
        mul_a = $signed({2'b00, ramp_pv});
        mul_b = $signed({9'd0, ramp_t});
      end
      jps_pkg::MUL_RECIP: begin
        mul_a = $signed({2'b00, pre_shifted[14:0]});
        mul_b = lin_fwd ? jps_pkg::RECIP_FWD : jps_pkg::RECIP_BWD;
      end
      default: begin
        mul_a = kp_sel;
        mul_b = $signed({err_q[15], err_q});
      end
    endcase
    prod_d = mul_a * mul_b;

    ydiff = $signed({{2{ytarget_q[15]}}, ytarget_q}) - $signed({{2{yaw_q[15]}}, yaw_q});

    if ((phase_q == jps_pkg::PH_PUSH) && lin_jump) begin
      vel_d = lin_bwd ? -$signed({5'd0, vel_mag}) : $signed({5'd0, vel_mag});
    end else begin
      vel_d = 16'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      if (cmd_i.mul_sel == jps_pkg::MUL_RAMP) begin
        err_q <= jps_pkg::wrap_angle(ydiff);
      end
      if (cmd_i.mul_sel == jps_pkg::MUL_YAW) begin
        vel_q <= vel_d;
      end
    end
  end

  // ---------------------------------------------------------------- commit
  logic [TIMER_WIDTH:0]   tsum, rsum;
  logic [TIMER_WIDTH-1:0] tadd, radd, push_wait;
  logic signed [33:0]     rnd_full;
  logic signed [19:0]     rnd, ff_sel, mr_sel, ysum, ycl;
  logic signed [17:0]     turn_ofs;

  always_comb begin
    tsum = {1'b0, ptimer_q} + {{(TIMER_WIDTH-7){1'b0}}, tick_q};
    rsum = {1'b0, relapsed_q} + {{(TIMER_WIDTH-7){1'b0}}, tick_q};
    tadd = tsum[TIMER_WIDTH] ? '1 : tsum[TIMER_WIDTH-1:0];
    radd = rsum[TIMER_WIDTH] ? '1 : rsum[TIMER_WIDTH-1:0];
    push_wait = lin_fwd ? WAIT_FWD : (lin_bwd ? WAIT_BWD : WAIT_NONE);

    // yaw rate: round the P term half up, add the feed-forward signed by turn direction, clamp
    rnd_full = prod_q + jps_pkg::ROUND_HALF;
    rnd      = rnd_full[31:12];
    ff_sel   = 20'sd0;
    mr_sel   = jps_pkg::MR_STRAIGHT;
    if (turn_jump) begin
      case (phase_q)
        jps_pkg::PH_PUSH: begin
          ff_sel = jps_pkg::FF_PUSH;
          mr_sel = jps_pkg::MR_PUSH;
        end
        jps_pkg::PH_FLY: begin
          ff_sel = jps_pkg::FF_FLY;
          mr_sel = jps_pkg::MR_FLY;
        end
        jps_pkg::PH_LAND:    mr_sel = jps_pkg::MR_LAND;
        jps_pkg::PH_RECOVER: mr_sel = jps_pkg::MR_RECOVER;
        default:             mr_sel = jps_pkg::MR_TURN;
      endcase
    end
    ysum = spin_cw ? (rnd - ff_sel) : (spin_ccw ? (rnd + ff_sel) : rnd);
    if (ysum > mr_sel) begin
      ycl = mr_sel;
    end else if (ysum < -mr_sel) begin
      ycl = -mr_sel;
    end else begin
      ycl = ysum;
    end

    turn_ofs = spin_ccw ? jps_pkg::Q_HALF_PI : (spin_cw ? -jps_pkg::Q_HALF_PI : 18'sd0);

    phase_d    = phase_q;
    ptimer_d   = ptimer_q;
    relapsed_d = relapsed_q;
    ytarget_d  = ytarget_q;
    res_d      = '0;

    if (op_q == jps_pkg::OP_START) begin
      phase_d    = jps_pkg::PH_PREPARE;
      ptimer_d   = '0;
      relapsed_d = '0;
      ytarget_d  = 16'sd0;
    end else begin
      res_d.linear_velocity    = vel_q;
      res_d.yaw_rate_cmd       = steer_jump ? ycl[15:0] : 16'sd0;
      res_d.yaw_control_on     = steer_jump;
      res_d.linear_feedback_on = lin_jump && (phase_q == jps_pkg::PH_PUSH);
      case (phase_q)
        jps_pkg::PH_PREPARE: begin
          ytarget_d = jps_pkg::wrap_angle($signed({{2{yaw_q[15]}}, yaw_q}) + turn_ofs);
          res_d.pose_valid         = 1'b1;
          res_d.pose_left          = jps_pkg::servo_sum(left_low_q, jps_pkg::SERVO_LOW_OFS);
          res_d.pose_right         = jps_pkg::servo_sum(right_low_q, -jps_pkg::SERVO_LOW_OFS);
          res_d.pose_aux_a         = jps_pkg::AUX_A_PREPARE;
          res_d.pose_aux_b         = jps_pkg::AUX_B_PREPARE;
          res_d.clear_yaw_integral = 1'b1;
          phase_d  = jps_pkg::PH_PUSH;
          ptimer_d = '0;
        end
        jps_pkg::PH_PUSH: begin
          ptimer_d = tadd;
          if (tadd >= push_wait) begin
            res_d.pose_valid = 1'b1;
            res_d.pose_left  = jps_pkg::servo_sum(left_high_q, jps_pkg::SERVO_HIGH_OFS);
            res_d.pose_right = jps_pkg::servo_sum(right_high_q, -jps_pkg::SERVO_HIGH_OFS);
            ptimer_d = '0;
            phase_d  = jps_pkg::PH_FLY;
          end
        end
        jps_pkg::PH_FLY: begin
          ptimer_d = tadd;
          if (tadd >= WAIT_FLY) begin
            res_d.pose_valid = 1'b1;
            res_d.pose_left  = jps_pkg::servo_sum(left_low_q, jps_pkg::SERVO_LOW_OFS);
            res_d.pose_right = jps_pkg::servo_sum(right_low_q, -jps_pkg::SERVO_LOW_OFS);
            ptimer_d = '0;
            phase_d  = jps_pkg::PH_LAND;
          end
        end
        jps_pkg::PH_LAND: begin
          ptimer_d = tadd;
          if (tadd >= WAIT_LAND) begin
            ptimer_d   = '0;
            relapsed_d = '0;
            phase_d    = jps_pkg::PH_RECOVER;
          end
        end
        default: begin
          // recover: stay here, flag done on every tick that meets the end condition
          relapsed_d = radd;
          ptimer_d   = stable_q ? tadd : '0;
          if ((ptimer_d >= WAIT_STBL) || (radd >= WAIT_TOUT)) begin
            res_d.clear_yaw_integral = 1'b1;
            res_d.finished           = 1'b1;
          end
        end
      endcase
      res_d.phase_now = phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jps_pkg::PH_PREPARE;
      ptimer_q   <= '0;
      relapsed_q <= '0;
      ytarget_q  <= 16'sd0;
    end else if (cmd_i.commit) begin
      phase_q    <= phase_d;
      ptimer_q   <= ptimer_d;
      relapsed_q <= relapsed_d;
      ytarget_q  <= ytarget_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o             = res_q;
  assign res_valid_o       = res_valid_q;
  assign status_o.res_free = !res_valid_q || res_ready_i;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> res_valid_q)
    else $error("committed word not presented");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == jps_pkg::OP_START)) |=>
      (phase_q == jps_pkg::PH_PREPARE) && (ptimer_q == '0) &&
      (relapsed_q == '0) && (ytarget_q == 16'sd0))
    else $error("start did not clear the jump state");

endmodule

@@ rtl/core/jump_phase_sequencer_top.sv @@
// Top level of the jump phase sequencer: channels, controller and datapath.
//
// Use: a host writes the configuration registers over cfg_i (index 0 jump kind,
// 1 max linear speed, 2..5 left/right servo low/high limits) while the block is idle.
// Each word on in_i is either a start (operation 0), which clears the jump state,
// or a tick carrying the elapsed milliseconds and the measured yaw, pitch and
// pitch rate. Every input word yields exactly one result word on res_o.
// The controller walks through load, three passes of the single shared multiplier
// (ramp product, reciprocal for the ramp division, yaw gain) and a commit step,
// one item at a time: a new input word is accepted only once the previous one
// has been committed to the output register.
// The result sits in an output register, so the next input word is accepted while
// the previous result still waits; if res_o stays stalled the controller holds in
// its commit step until the register frees up.
// Reset: asynchronous, active low. It returns the phase to prepare, clears the
// timers and yaw target, and loads the register defaults (no jump, speed 1638,
// full servo range). The configuration channel is always ready.
module jump_phase_sequencer_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jps_in_if.sink      in_i,
  jps_res_if.source   res_o,
  jps_cfg_if.sink     cfg_i
);

  jps_pkg::jps_cmd_t    cmd;
  jps_pkg::jps_status_t status;
  jps_pkg::jps_res_t    res;
  logic                 res_valid;

  jps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jps_dp #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (in_i.operation),
    .tick_length_i (in_i.tick_length),
    .yaw_now_i     (in_i.yaw_now),
    .pitch_now_i   (in_i.pitch_now),
    .pitch_speed_i (in_i.pitch_speed),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .res_o         (res),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_o.ready)
  );

  // register writes never stall
  assign cfg_i.ready = 1'b1;

  // unpack the result word onto the channel
  assign res_o.valid              = res_valid;
  assign res_o.pose_valid         = res.pose_valid;
  assign res_o.pose_left          = res.pose_left;
  assign res_o.pose_right         = res.pose_right;
  assign res_o.pose_aux_a         = res.pose_aux_a;
  assign res_o.pose_aux_b         = res.pose_aux_b;
  assign res_o.linear_velocity    = res.linear_velocity;
  assign res_o.yaw_rate_cmd       = res.yaw_rate_cmd;
  assign res_o.yaw_control_on     = res.yaw_control_on;
  assign res_o.linear_feedback_on = res.linear_feedback_on;
  assign res_o.clear_yaw_integral = res.clear_yaw_integral;
  assign res_o.finished           = res.finished;
  assign res_o.phase_now          = res.phase_now;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the jump phase sequencer: predicts and checks every command word.
module testbench;
  import jps_pkg::*;

  localparam int   TIMER_BITS    = 16;
  localparam int   TIMER_TOP     = (1 << TIMER_BITS) - 1;
  localparam int   WORD_GOAL     = 1550;
  localparam int   SETTLE_CYCLES = 8;
  localparam logic OP_TICK       = 1'b1;
  // Q3.12 angles
  localparam int   ANG_PI        = 12868;
  localparam int   ANG_TWO_PI    = 25736;
  localparam int   ANG_HALF_PI   = 6434;

  typedef struct {
    logic               op;
    logic [7:0]         tick;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] prate;
    int                 gap;
  } jump_word_t;

  typedef struct {
    logic [2:0]  index;
    logic [14:0] data;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  jps_in_if  word_if();
  jps_res_if cmd_if();
  jps_cfg_if reg_if();

  jump_phase_sequencer_top #(
    .TIMER_WIDTH(TIMER_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_if),
    .res_o  (cmd_if),
    .cfg_i  (reg_if)
  );

  // Shadow copy of the register file, loaded with the reset defaults
  logic [2:0]  kind_reg   = 3'd0;
  logic [14:0] speed_reg  = 15'd1638;
  logic [11:0] left_lo    = 12'd0;
  logic [11:0] left_hi    = 12'd4095;
  logic [11:0] right_lo   = 12'd0;
  logic [11:0] right_hi   = 12'd4095;

  // Shadow copy of the jump state
  jps_phase_e ph       = PH_PREPARE;
  int         ph_timer = 0;
  int         rec_time = 0;
  int         yaw_goal = 0;

  // Words waiting to be sent, register writes waiting, and commands still owed by the block
  jump_word_t word_q[$];
  reg_write_t reg_q[$];
  jps_res_t   pending_cmds[$];
  jump_word_t cur_word;

  int gap_cnt      = 0;
  int hold_cnt     = 0;
  int src_mode     = 0;
  int sink_mode    = 0;
  int words_queued = 0;
  int regs_queued  = 0;
  int regs_written = 0;
  int results_in   = 0;
  int jumps_done   = 0;
  int settings     = 0;
  int mismatches   = 0;

  // ---------------------------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------------------------

  // Fold an angle into (-PI, PI]
  function automatic int wrap_q(int a);
    while (a > ANG_PI) a -= ANG_TWO_PI;
    while (a <= -ANG_PI) a += ANG_TWO_PI;
    return a;
  endfunction

  // Advance a timer, sticking at its top value
  function automatic int sat_add(int t, int d);
    return (t + d > TIMER_TOP) ? TIMER_TOP : t + d;
  endfunction

  // Servo limit plus offset, held inside 0..4095
  function automatic logic [11:0] servo_clamp(logic [11:0] base, int ofs);
    int s;
    s = int'(base) + ofs;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[11:0];
  endfunction

  function automatic void apply_reg(logic [2:0] index, logic [14:0] data);
    case (index)
      REG_JUMP_KIND:  kind_reg  = data[2:0];
      REG_MAX_SPEED:  speed_reg = data;
      REG_LEFT_LOW:   left_lo   = data[11:0];
      REG_LEFT_HIGH:  left_hi   = data[11:0];
      REG_RIGHT_LOW:  right_lo  = data[11:0];
      REG_RIGHT_HIGH: right_hi  = data[11:0];
      default: ;
    endcase
  endfunction

  // Work out the command word for one input word and advance the shadow state
  function automatic jps_res_t predict_word(jump_word_t w);
    jps_res_t r;
    int       lin_dir, spin_dir, ramp, cap, span, pv, vel, err, kp, mr, ff, dwell, ap, ar;
    longint   ycmd;
    logic     steer_on;
    r        = '0;
    lin_dir  = 0;
    spin_dir = 0;
    vel      = 0;
    ycmd     = 0;
    // A start clears everything and answers with an all-zero word
    if (w.op == OP_START) begin
      ph       = PH_PREPARE;
      ph_timer = 0;
      rec_time = 0;
      yaw_goal = 0;
      return r;
    end
    case (kind_reg)
      JK_FORWARD:    lin_dir  = 1;
      JK_BACKWARD:   lin_dir  = -1;
      JK_TURN_LEFT:  spin_dir = 1;
      JK_TURN_RIGHT: spin_dir = -1;
      default: ;
    endcase
    steer_on = (lin_dir != 0) || (spin_dir != 0);

    // Push ramp, from the timer held before this word
    if (ph == PH_PUSH && lin_dir != 0) begin
      ramp = (lin_dir > 0) ? 160 : 240;
      cap  = (lin_dir > 0) ? 1638 : 1393;
      span = (ph_timer < ramp) ? ph_timer : ramp;
      pv   = (int'(speed_reg) < cap) ? int'(speed_reg) : cap;
      vel  = (pv * span) / ramp;
      if (lin_dir < 0) vel = -vel;
    end

    // Yaw loop, from the phase and target held before this word
    if (steer_on) begin
      err = wrap_q(yaw_goal - int'(w.yaw));
      ff  = 0;
      kp  = (spin_dir == 0) ? 12288 : 4096;
      mr  = (spin_dir == 0) ? 7373 : 2458;
      if (spin_dir != 0) begin
        case (ph)
          PH_PUSH: begin
            ff = 4915;
            kp = 5734;
            mr = 7373;
          end
          PH_FLY: begin
            ff = 26214;
            kp = 8192;
            mr = 26214;
          end
          PH_LAND: begin
            kp = 1434;
            mr = 1638;
          end
          PH_RECOVER: begin
            kp = 3277;
            mr = 2048;
          end
          default: ;
        endcase
      end
      ycmd = longint'(spin_dir * ff) + ((longint'(kp) * longint'(err) + 2048) >>> 12);
      if (ycmd > mr) ycmd = mr;
      if (ycmd < -mr) ycmd = -mr;
    end

    r.linear_velocity    = vel[15:0];
    r.yaw_rate_cmd       = ycmd[15:0];
    r.yaw_control_on     = steer_on;
    r.linear_feedback_on = (lin_dir != 0) && (ph == PH_PUSH);

    case (ph)
      PH_PREPARE: begin
        yaw_goal             = wrap_q(int'(w.yaw) + spin_dir * ANG_HALF_PI);
        r.pose_valid         = 1'b1;
        r.pose_left          = servo_clamp(left_lo, 60);
        r.pose_right         = servo_clamp(right_lo, -60);
        r.pose_aux_a         = 9'd450;
        r.pose_aux_b         = 8'd250;
        r.clear_yaw_integral = 1'b1;
        ph                   = PH_PUSH;
        ph_timer             = 0;
      end
      PH_PUSH: begin
        dwell    = (lin_dir > 0) ? 650 : ((lin_dir < 0) ? 700 : 200);
        ph_timer = sat_add(ph_timer, int'(w.tick));
        if (ph_timer >= dwell) begin
          r.pose_valid = 1'b1;
          r.pose_left  = servo_clamp(left_hi, 20);
          r.pose_right = servo_clamp(right_hi, -20);
          ph_timer     = 0;
          ph           = PH_FLY;
        end
      end
      PH_FLY: begin
        ph_timer = sat_add(ph_timer, int'(w.tick));
        if (ph_timer >= 130) begin
          r.pose_valid = 1'b1;
          r.pose_left  = servo_clamp(left_lo, 60);
          r.pose_right = servo_clamp(right_lo, -60);
          ph_timer     = 0;
          ph           = PH_LAND;
        end
      end
      PH_LAND: begin
        ph_timer = sat_add(ph_timer, int'(w.tick));
        if (ph_timer >= 260) begin
          ph_timer = 0;
          rec_time = 0;
          ph       = PH_RECOVER;
        end
      end
      default: begin
        // Recover: stays put, finishing whenever the pitch has stayed in its window long enough or the timeout is met
        ap       = (w.pitch < 0) ? -int'(w.pitch) : int'(w.pitch);
        ar       = (w.prate < 0) ? -int'(w.prate) : int'(w.prate);
        rec_time = sat_add(rec_time, int'(w.tick));
        if (ap <= 737 && ar <= 6553) ph_timer = sat_add(ph_timer, int'(w.tick));
        else ph_timer = 0;
        if (ph_timer >= 80 || rec_time >= 350) begin
          r.clear_yaw_integral = 1'b1;
          r.finished           = 1'b1;
        end
      end
    endcase
    r.phase_now = ph;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Clock, idle pattern and field check
  // ---------------------------------------------------------------------------------------------

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle gap per word: none in mode 0, a random one in mode 1, and in mode 2 only now and then
  function automatic int idle_draw(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(16, 0);
    return ($urandom_range(3, 0) == 0) ? $urandom_range(16, 1) : 0;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Input word driver: present each queued word after its drawn gap, hold it until taken
  // ---------------------------------------------------------------------------------------------

  always @(posedge clk_i) begin : word_drive
    logic show;
    show = word_if.valid;
    if (word_if.valid && word_if.ready) begin
      // Taken: predict its command now, in input order
      pending_cmds.push_back(predict_word(cur_word));
      show = 1'b0;
    end
    if (!show && word_q.size() != 0) begin
      if (gap_cnt < word_q[0].gap) begin
        gap_cnt++;
      end else begin
        cur_word              = word_q.pop_front();
        gap_cnt               = 0;
        show                  = 1'b1;
        word_if.operation   <= cur_word.op;
        word_if.tick_length <= cur_word.tick;
        word_if.yaw_now     <= cur_word.yaw;
        word_if.pitch_now   <= cur_word.pitch;
        word_if.pitch_speed <= cur_word.prate;
      end
    end
    // Single update of valid per edge, so a back-to-back word keeps it high
    word_if.valid <= show;
  end

  // ---------------------------------------------------------------------------------------------
  // Register write driver: the shadow registers follow each accepted write
  // ---------------------------------------------------------------------------------------------

  always @(posedge clk_i) begin : reg_drive
    reg_write_t nxt;
    logic       show;
    show = reg_if.valid;
    if (reg_if.valid && reg_if.ready) begin
      apply_reg(reg_if.index, reg_if.data);
      regs_written++;
      show = 1'b0;
    end
    if (!show && reg_q.size() != 0) begin
      nxt           = reg_q.pop_front();
      show          = 1'b1;
      reg_if.index <= nxt.index;
      reg_if.data  <= nxt.data;
    end
    reg_if.valid <= show;
  end

  // ---------------------------------------------------------------------------------------------
  // Command monitor: check each taken word against the oldest prediction, then stall at random
  // ---------------------------------------------------------------------------------------------

  always @(posedge clk_i) begin : cmd_watch
    jps_res_t want;
    logic     nxt_ready;
    nxt_ready = cmd_if.ready;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      results_in++;
      if (pending_cmds.size() == 0) begin
        $error("command word arrived with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        compare_field("pose_valid", want.pose_valid, cmd_if.pose_valid);
        compare_field("pose_left", want.pose_left, cmd_if.pose_left);
        compare_field("pose_right", want.pose_right, cmd_if.pose_right);
        compare_field("pose_aux_a", want.pose_aux_a, cmd_if.pose_aux_a);
        compare_field("pose_aux_b", want.pose_aux_b, cmd_if.pose_aux_b);
        compare_field("linear_velocity", want.linear_velocity, cmd_if.linear_velocity);
        compare_field("yaw_rate_cmd", want.yaw_rate_cmd, cmd_if.yaw_rate_cmd);
        compare_field("yaw_control_on", want.yaw_control_on, cmd_if.yaw_control_on);
        compare_field("linear_feedback_on", want.linear_feedback_on,
                      cmd_if.linear_feedback_on);
        compare_field("clear_yaw_integral", want.clear_yaw_integral,
                      cmd_if.clear_yaw_integral);
        compare_field("finished", want.finished, cmd_if.finished);
        compare_field("phase_now", want.phase_now, cmd_if.phase_now);
      end
      if (cmd_if.finished === 1'b1) jumps_done++;
      hold_cnt  = idle_draw(sink_mode);
      nxt_ready = (hold_cnt == 0);
    end else if (!cmd_if.ready) begin
      if (hold_cnt > 0) hold_cnt--;
      nxt_ready = (hold_cnt == 0);
    end
    cmd_if.ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------------

  task automatic push_word(logic op, int tick, int yaw, int pitch, int prate);
    jump_word_t w;
    w.op    = op;
    w.tick  = tick[7:0];
    w.yaw   = yaw[15:0];
    w.pitch = pitch[15:0];
    w.prate = prate[15:0];
    w.gap   = idle_draw(src_mode);
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic set_reg(logic [2:0] index, int data);
    reg_write_t w;
    w.index = index;
    w.data  = data[14:0];
    reg_q.push_back(w);
    regs_queued++;
  endtask

  // Hold off until every word and write has gone through and every command is back
  task automatic settle();
    while (results_in < words_queued || regs_written < regs_queued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_servo();
    case ($urandom_range(4, 0))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(80, 0);
      3:       return $urandom_range(4095, 4015);
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  // New register setting: always a jump kind, the rest now and then
  task automatic pick_settings();
    int k;
    k = $urandom_range(11, 0);
    if (k < 8) set_reg(REG_JUMP_KIND, (k % 4) + 1);
    else if (k == 8) set_reg(REG_JUMP_KIND, 0);
    else set_reg(REG_JUMP_KIND, k - 4);
    if ($urandom_range(1, 0) != 0) begin
      case ($urandom_range(4, 0))
        0:       set_reg(REG_MAX_SPEED, 0);
        1:       set_reg(REG_MAX_SPEED, 32767);
        2:       set_reg(REG_MAX_SPEED, 1393);
        3:       set_reg(REG_MAX_SPEED, $urandom_range(2000, 1));
        default: set_reg(REG_MAX_SPEED, $urandom_range(32767, 0));
      endcase
    end
    if ($urandom_range(1, 0) != 0) set_reg(REG_LEFT_LOW, pick_servo());
    if ($urandom_range(1, 0) != 0) set_reg(REG_LEFT_HIGH, pick_servo());
    if ($urandom_range(1, 0) != 0) set_reg(REG_RIGHT_LOW, pick_servo());
    if ($urandom_range(1, 0) != 0) set_reg(REG_RIGHT_HIGH, pick_servo());
    settings++;
  endtask

  // One jump: a start and a run of ticks. A tidy jump has no stray starts, an untidy one
  // skips the opening start and may restart anywhere.
  task automatic run_jump(int ticks, bit tidy);
    int base, yaw, pitch, prate, tick, c;
    logic op;
    base = int'($urandom_range(65535, 0)) - 32768;
    if (tidy) push_word(OP_START, $urandom_range(255, 0), $urandom_range(65535, 0),
                        $urandom_range(65535, 0), $urandom_range(65535, 0));
    repeat (ticks) begin
      op = (!tidy && $urandom_range(7, 0) == 0) ? OP_START : OP_TICK;
      c  = $urandom_range(9, 0);
      if (c < 7) tick = $urandom_range(255, 20);
      else if (c < 9) tick = $urandom_range(19, 0);
      else tick = ($urandom_range(1, 0) != 0) ? 255 : 0;
      // Mostly keep yaw near a base heading or a quarter turn off it; otherwise any yaw
      c = $urandom_range(9, 0);
      if (c < 4) yaw = int'($urandom_range(65535, 0)) - 32768;
      else yaw = base + (int'($urandom_range(2, 0)) - 1) * ANG_HALF_PI
                 + int'($urandom_range(1200, 0)) - 600;
      pitch = ($urandom_range(9, 0) < 7) ? int'($urandom_range(1474, 0)) - 737
                                         : int'($urandom_range(65535, 0)) - 32768;
      prate = ($urandom_range(9, 0) < 7) ? int'($urandom_range(13106, 0)) - 6553
                                         : int'($urandom_range(65535, 0)) - 32768;
      push_word(op, tick, yaw, pitch, prate);
    end
  endtask

  // Sit in recover long enough for both recover timers to stick at their top value
  task automatic soak_recover();
    push_word(OP_START, 0, 0, 0, 0);
    repeat (320) push_word(OP_TICK, 255, $urandom_range(65535, 0),
                           int'($urandom_range(200, 0)) - 100,
                           int'($urandom_range(2000, 0)) - 1000);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------------

  initial begin : stimulus
    int round;
    rst_ni                = 1'b0;
    word_if.valid         = 1'b0;
    word_if.operation     = OP_START;
    word_if.tick_length   = '0;
    word_if.yaw_now       = '0;
    word_if.pitch_now     = '0;
    word_if.pitch_speed   = '0;
    cmd_if.ready          = 1'b0;
    reg_if.valid          = 1'b0;
    reg_if.index          = REG_JUMP_KIND;
    reg_if.data           = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: forward jump with the servo sums pushed into saturation both ways
    set_reg(REG_JUMP_KIND, JK_FORWARD);
    set_reg(REG_MAX_SPEED, 32767);
    set_reg(REG_LEFT_LOW, 4095);
    set_reg(REG_LEFT_HIGH, 4095);
    set_reg(REG_RIGHT_LOW, 0);
    set_reg(REG_RIGHT_HIGH, 0);
    settings++;
    settle();
    push_word(OP_START, 255, -1, -1, -1);
    push_word(OP_TICK, 0, -32768, 0, 0);        // prepare: target wrapped from the lowest yaw
    push_word(OP_TICK, 100, 32767, 0, 0);       // push from a zero timer
    push_word(OP_TICK, 60, 0, 0, 0);            // part way up the ramp
    push_word(OP_TICK, 255, 4096, 0, 0);        // ramp exactly complete
    push_word(OP_TICK, 255, -4096, 0, 0);       // past the push time: fly
    push_word(OP_TICK, 129, 100, 0, 0);
    push_word(OP_TICK, 1, 100, 0, 0);           // fly time met: land
    push_word(OP_TICK, 255, 0, 0, 0);
    push_word(OP_TICK, 5, 0, 0, 0);             // land time met: recover
    push_word(OP_TICK, 79, 0, 737, 6553);       // on the edge of the stable window
    push_word(OP_TICK, 1, 0, -737, -6553);      // stable long enough: finished
    push_word(OP_TICK, 10, 0, 738, 0);          // just outside the window: stable time drops
    push_word(OP_TICK, 255, 0, -32768, 32767);
    push_word(OP_TICK, 5, 0, 0, -32768);        // recover timeout reached
    settle();

    // An unused jump kind behaves as no jump
    set_reg(REG_JUMP_KIND, 7);
    settings++;
    settle();
    push_word(OP_START, 0, 0, 0, 0);
    push_word(OP_TICK, 200, 1234, 0, 0);
    push_word(OP_TICK, 200, -1234, 0, 0);
    settle();

    // Left turn: the quarter-turn target wraps twice from the highest yaw
    set_reg(REG_JUMP_KIND, JK_TURN_LEFT);
    settings++;
    settle();
    push_word(OP_START, 0, 0, 0, 0);
    push_word(OP_TICK, 50, 32767, 0, 0);
    push_word(OP_TICK, 255, -32768, 0, 0);
    push_word(OP_TICK, 0, 0, 0, 0);
    settle();

    // Random rounds: a fresh setting, a fresh idle pattern, then a few jumps (a recover soak in round 4)
    for (round = 0; words_queued < WORD_GOAL; round++) begin
      pick_settings();
      settle();
      src_mode  = $urandom_range(2, 0);
      sink_mode = $urandom_range(2, 0);
      if (round == 4) begin
        soak_recover();
      end else begin
        repeat ($urandom_range(4, 1)) run_jump($urandom_range(30, 6), $urandom_range(7, 0) != 0);
      end
      settle();
    end

    if (pending_cmds.size() != 0) begin
      $error("%0d predicted command words never arrived", pending_cmds.size());
      mismatches++;
    end
    $display("Covered %0d input words under %0d register settings (%0d register writes).",
             words_queued, settings, regs_written);
    $display("Checked %0d command words, %0d of them marking a finished jump.",
             results_in, jumps_done);
    if (mismatches == 0) begin
      $display("[jump_phase_sequencer_top] OK");
    end else begin
      $display("[jump_phase_sequencer_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("[jump_phase_sequencer_top] ERROR");
    $finish;
  end

endmodule
